[src/msr_pkg.sv]
// Shared types, constants and the helper function of the servo ramp block.
`timescale 1ns / 1ps
`default_nettype none

package msr_pkg;

    // Channels that own limit bytes in the configuration registers.
    localparam int LIMIT_CH       = 10;
    localparam int LIMITS_PER_REG = 5;
    localparam int ANGLE_W        = 8;
    localparam int PULSE_W        = 12;
    localparam int CHAN_W         = 4;
    localparam int CFG_DATA_W     = 40;
    localparam int CFG_INDEX_W    = 3;
    localparam int PRESENT_W      = 10;

    // Operation codes of an input transaction.
    localparam logic OP_SWITCH = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_START = 8'd90;

    // pulse = 500 + angle * 2000 / 180, with the division done as a Q16
    // reciprocal multiply: 2000 / 180 * 65536 rounded up.
    localparam logic [PULSE_W-1:0] PULSE_BASE  = 12'd500;
    localparam logic [19:0]        PULSE_SCALE = 20'd728178;
    localparam int                 PULSE_SHIFT = 16;
    localparam int                 PROD_W      = 28;

    // Task queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOWER_FIRST  = 3'd0,
        CFG_LOWER_SECOND = 3'd1,
        CFG_UPPER_FIRST  = 3'd2,
        CFG_UPPER_SECOND = 3'd3,
        CFG_PRESENT      = 3'd4
    } msr_cfg_index_t;

    typedef enum logic [2:0] {
        EV_START     = 3'd0,
        EV_DRIVE     = 3'd1,
        EV_BUSY      = 3'd2,
        EV_BAD       = 3'd3,
        EV_NO_LIMITS = 3'd4
    } msr_event_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CMD,
        B_DRIVE,
        B_SCAN
    } msr_back_state_t;

    // One decoded transaction, as the front hands it to the back.
    typedef struct packed {
        logic               tick;
        logic               bad;
        logic               has_limits;
        logic [CHAN_W-1:0]  channel;
        logic [ANGLE_W-1:0] target;
    } msr_task_t;

    typedef struct packed {
        msr_event_t         kind;
        logic [CHAN_W-1:0]  channel;
        logic [ANGLE_W-1:0] angle;
        logic [PULSE_W-1:0] pulse_width;
        logic               reached;
        logic               last;
    } msr_result_t;

    function automatic logic [PULSE_W-1:0] pulse_of(input logic [ANGLE_W-1:0] deg);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(deg) * PROD_W'(PULSE_SCALE);
        return PULSE_BASE + PULSE_W'(prod >> PULSE_SHIFT);
    endfunction

endpackage

`default_nettype wire

[src/msr_in_if.sv]
// Command and tick input channel.
`timescale 1ns / 1ps
`default_nettype none

interface msr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [msr_pkg::CHAN_W-1:0]    channel;
    logic                          switch_on;

    modport source (output valid, output operation, output channel, output switch_on,
                    input ready);
    modport sink   (input valid, input operation, input channel, input switch_on,
                    output ready);
endinterface

`default_nettype wire

[src/msr_out_if.sv]
// Result output channel.
`timescale 1ns / 1ps
`default_nettype none

interface msr_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    event_kind;
    logic [msr_pkg::CHAN_W-1:0]    out_channel;
    logic [msr_pkg::ANGLE_W-1:0]   angle;
    logic [msr_pkg::PULSE_W-1:0]   pulse_width;
    logic                          reached;
    logic                          last;

    modport source (output valid, output event_kind, output out_channel, output angle,
                    output pulse_width, output reached, output last, input ready);
    modport sink   (input valid, input event_kind, input out_channel, input angle,
                    input pulse_width, input reached, input last, output ready);
endinterface

`default_nettype wire

[src/msr_cfg_if.sv]
// Configuration write channel.
`timescale 1ns / 1ps
`default_nettype none

interface msr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [msr_pkg::CFG_INDEX_W-1:0]   index;
    logic [msr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/msr_front.sv]
// Front end: configuration registers, command decode and limit lookup.
`timescale 1ns / 1ps
`default_nettype none

module msr_front #(
    parameter int CHANNELS = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    msr_cfg_if.sink                cfg,
    msr_in_if.sink                 item,
    input  wire logic              full,
    output logic                   push,
    output msr_pkg::msr_task_t     push_data
);

    logic [msr_pkg::CFG_DATA_W-1:0] lower_first_reg;
    logic [msr_pkg::CFG_DATA_W-1:0] lower_second_reg;
    logic [msr_pkg::CFG_DATA_W-1:0] upper_first_reg;
    logic [msr_pkg::CFG_DATA_W-1:0] upper_second_reg;
    logic [msr_pkg::PRESENT_W-1:0]  present_reg;

    logic [msr_pkg::ANGLE_W-1:0] lo_lim [msr_pkg::LIMIT_CH];
    logic [msr_pkg::ANGLE_W-1:0] up_lim [msr_pkg::LIMIT_CH];
    logic [msr_pkg::ANGLE_W-1:0] limit;
    logic                        in_table;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_first_reg  <= '0;
            lower_second_reg <= '0;
            upper_first_reg  <= '0;
            upper_second_reg <= '0;
            present_reg      <= '0;
        end
        else if (cfg.valid)
        begin
            case (msr_pkg::msr_cfg_index_t'(cfg.index))
                msr_pkg::CFG_LOWER_FIRST:  lower_first_reg  <= cfg.data;
                msr_pkg::CFG_LOWER_SECOND: lower_second_reg <= cfg.data;
                msr_pkg::CFG_UPPER_FIRST:  upper_first_reg  <= cfg.data;
                msr_pkg::CFG_UPPER_SECOND: upper_second_reg <= cfg.data;
                msr_pkg::CFG_PRESENT:      present_reg      <= cfg.data[msr_pkg::PRESENT_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the limit bytes, channel 0 in the low byte of each first register.
    always_comb
    begin
        for (int i = 0; i < msr_pkg::LIMITS_PER_REG; i++)
        begin
            lo_lim[i]                          = lower_first_reg[8*i +: 8];
            lo_lim[i + msr_pkg::LIMITS_PER_REG] = lower_second_reg[8*i +: 8];
            up_lim[i]                          = upper_first_reg[8*i +: 8];
            up_lim[i + msr_pkg::LIMITS_PER_REG] = upper_second_reg[8*i +: 8];
        end
    end

    assign in_table = (int'(item.channel) < msr_pkg::LIMIT_CH);
    assign limit    = !in_table      ? '0 :
                      item.switch_on ? up_lim[item.channel] : lo_lim[item.channel];

    assign item.ready = !full;
    assign push       = item.valid && !full;

    always_comb
    begin
        push_data.tick       = (item.operation == msr_pkg::OP_TICK);
        push_data.bad        = (int'(item.channel) >= CHANNELS);
        push_data.has_limits = in_table && present_reg[item.channel];
        push_data.channel    = item.channel;
        push_data.target     = (limit > msr_pkg::ANGLE_MAX) ? msr_pkg::ANGLE_MAX : limit;
    end

endmodule

`default_nettype wire

[src/msr_queue.sv]
// Two-entry task queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module msr_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire msr_pkg::msr_task_t    push_data,
    output logic                       full,
    input  wire logic                  pop,
    output msr_pkg::msr_task_t         pop_data,
    output logic                       not_empty
);

    msr_pkg::msr_task_t                 entry_reg [msr_pkg::QUEUE_DEPTH];
    logic [msr_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [msr_pkg::QPTR_W-1:0]         wr_ptr_next;
    logic [msr_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [msr_pkg::QPTR_W-1:0]         rd_ptr_next;
    logic [msr_pkg::QCNT_W-1:0]         count_reg;
    logic [msr_pkg::QCNT_W-1:0]         count_next;

    assign full      = (count_reg == msr_pkg::QCNT_W'(msr_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= msr_pkg::QCNT_W'(msr_pkg::QUEUE_DEPTH))
        else $error("task queue count above depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("task queue popped while empty");

endmodule

`default_nettype wire

[src/msr_back.sv]
// Back end: channel state, command execution, tick scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module msr_back #(
    parameter int CHANNELS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire msr_pkg::msr_task_t    q_data,
    output logic                       q_pop,
    msr_out_if.source                  result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    msr_pkg::msr_back_state_t   state_reg;
    msr_pkg::msr_back_state_t   state_next;
    msr_pkg::msr_task_t         cur_reg;
    msr_pkg::msr_task_t         cur_next;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;
    logic [CHANNELS-1:0]        busy_reg;
    logic [CHANNELS-1:0]        busy_next;

    logic [msr_pkg::ANGLE_W-1:0] pos_mem  [CHANNELS];
    logic [msr_pkg::ANGLE_W-1:0] goal_mem [CHANNELS];
    logic                        pos_we;
    logic [msr_pkg::ANGLE_W-1:0] pos_wdata;
    logic                        goal_we;

    msr_pkg::msr_result_t       res_reg;
    msr_pkg::msr_result_t       res_next;
    logic                       res_valid_reg;
    logic                       res_valid_next;
    logic                       out_load;
    logic                       out_free;

    logic                        busy_sel;
    logic                        busy_above;
    logic                        accept_cmd;
    logic [msr_pkg::ANGLE_W-1:0] pos_cur;
    logic [msr_pkg::ANGLE_W-1:0] goal_cur;
    logic [msr_pkg::ANGLE_W-1:0] pos_step;

    assign out_free = !res_valid_reg || result.ready;
    assign busy_sel = busy_reg[idx_reg];
    assign pos_cur  = pos_mem[idx_reg];
    assign goal_cur = goal_mem[idx_reg];

    // Any busy channel above the one under the scan pointer ends the tick when clear.
    always_comb
    begin
        busy_above = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            busy_above = busy_above | (busy_reg[i] && (i > int'(idx_reg)));
        end
    end

    assign pos_step   = (pos_cur < goal_cur) ? pos_cur + 1'b1 :
                        (pos_cur > goal_cur) ? pos_cur - 1'b1 : pos_cur;
    assign accept_cmd = !cur_reg.bad && !busy_sel && cur_reg.has_limits;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msr_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_data.tick ? msr_pkg::B_SCAN : msr_pkg::B_CMD;
                end
            end
            msr_pkg::B_CMD:
            begin
                if (out_free)
                begin
                    state_next = accept_cmd ? msr_pkg::B_DRIVE : msr_pkg::B_IDLE;
                end
            end
            msr_pkg::B_DRIVE:
            begin
                if (out_free)
                begin
                    state_next = msr_pkg::B_IDLE;
                end
            end
            msr_pkg::B_SCAN:
            begin
                if ((!busy_sel || out_free) && !busy_above)
                begin
                    state_next = msr_pkg::B_IDLE;
                end
            end
            default: state_next = msr_pkg::B_IDLE;
        endcase
    end

    // Datapath controls and result composition.
    always_comb
    begin
        q_pop     = 1'b0;
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        pos_we    = 1'b0;
        pos_wdata = pos_step;
        goal_we   = 1'b0;
        out_load  = 1'b0;
        res_next  = res_reg;
        case (state_reg)
            msr_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    idx_next = q_data.tick ? '0 : IDX_W'(q_data.channel);
                end
            end
            msr_pkg::B_CMD:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    res_next.channel     = cur_reg.channel;
                    res_next.angle       = '0;
                    res_next.pulse_width = '0;
                    res_next.reached     = 1'b0;
                    res_next.last        = 1'b1;
                    if (cur_reg.bad)
                    begin
                        res_next.kind = msr_pkg::EV_BAD;
                    end
                    else if (busy_sel)
                    begin
                        res_next.kind = msr_pkg::EV_BUSY;
                    end
                    else if (!cur_reg.has_limits)
                    begin
                        res_next.kind = msr_pkg::EV_NO_LIMITS;
                    end
                    else
                    begin
                        res_next.kind      = msr_pkg::EV_START;
                        res_next.angle     = cur_reg.target;
                        res_next.last      = 1'b0;
                        goal_we            = 1'b1;
                        pos_we             = 1'b1;
                        pos_wdata          = msr_pkg::ANGLE_START;
                        busy_next[idx_reg] = (cur_reg.target != msr_pkg::ANGLE_START);
                    end
                end
            end
            msr_pkg::B_DRIVE:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    res_next.kind        = msr_pkg::EV_DRIVE;
                    res_next.channel     = cur_reg.channel;
                    res_next.angle       = msr_pkg::ANGLE_START;
                    res_next.pulse_width = msr_pkg::pulse_of(msr_pkg::ANGLE_START);
                    res_next.reached     = (cur_reg.target == msr_pkg::ANGLE_START);
                    res_next.last        = 1'b1;
                end
            end
            msr_pkg::B_SCAN:
            begin
                if (busy_sel && out_free)
                begin
                    out_load             = 1'b1;
                    pos_we               = 1'b1;
                    busy_next[idx_reg]   = (pos_step != goal_cur);
                    res_next.kind        = msr_pkg::EV_DRIVE;
                    res_next.channel     = msr_pkg::CHAN_W'(idx_reg);
                    res_next.angle       = pos_step;
                    res_next.pulse_width = msr_pkg::pulse_of(pos_step);
                    res_next.reached     = (pos_step == goal_cur);
                    res_next.last        = !busy_above;
                end
                if ((!busy_sel || out_free) && busy_above)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
        res_valid_next = out_load ? 1'b1 : (result.ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msr_pkg::B_IDLE;
            busy_reg      <= '0;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        if (pos_we)
        begin
            pos_mem[idx_reg] <= pos_wdata;
        end
        if (goal_we)
        begin
            goal_mem[idx_reg] <= cur_reg.target;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.event_kind  = res_reg.kind;
    assign result.out_channel = res_reg.channel;
    assign result.angle       = res_reg.angle;
    assign result.pulse_width = res_reg.pulse_width;
    assign result.reached     = res_reg.reached;
    assign result.last        = res_reg.last;

    a_start_then_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && res_next.kind == msr_pkg::EV_START |=> state_reg == msr_pkg::B_DRIVE)
        else $error("started result not followed by first drive");

    a_reached_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && res_next.kind == msr_pkg::EV_DRIVE && res_next.reached
        |=> !busy_reg[$past(idx_reg)])
        else $error("channel still busy after reaching target");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == msr_pkg::B_SCAN && busy_sel |-> pos_cur <= msr_pkg::ANGLE_MAX)
        else $error("busy channel position beyond travel");

endmodule

`default_nettype wire

[src/multichannel_servo_ramp.sv]
// Top level of the multichannel servo ramp driver.
//
// Switch commands and step ticks enter on the item channel; results leave on the
// result channel, each transaction carrying one result, with last set on the final
// result of an input transaction. In the back end a command answers from the
// command state, and one that starts a move goes on to the drive state (started,
// then a drive pulse at 90 degrees). A tick scans channels from 0 upward, one channel
// per cycle while no busy channel's result waits on the receiver, and stops after
// the highest busy channel; a tick with no busy channel gives no result. Result
// back-pressure holds the back end while a finished result waits on a receiver that
// is not ready. The front end decodes commands and looks up clamped limits while the
// back end works, and a two-deep queue between them lets the item channel keep
// accepting. Limit and limits-present registers are written on the cfg channel,
// which is always ready; write them only while the block is idle. Position and goal
// of a channel are only meaningful while that channel is busy.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_servo_ramp #(
    parameter int CHANNELS = 10
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    msr_cfg_if.sink    cfg,
    msr_in_if.sink     item,
    msr_out_if.source  result
);

    // Task hand-off between front and back.
    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 not_empty;
    msr_pkg::msr_task_t   push_data;
    msr_pkg::msr_task_t   pop_data;

    // Decode commands, hold configuration.
    msr_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item      (item),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    // Buffer decoded transactions so the input keeps flowing during a tick scan.
    msr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    // Execute commands and ticks, own the channel state and the result register.
    msr_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (not_empty),
        .q_data  (pop_data),
        .q_pop   (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the multichannel servo ramp driver.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_CH       = 10;
    localparam int IDLE_PCT     = 21;   // chance of an idle cycle on either side
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off to fill the block
    localparam int DRAIN_CYCLES = 2 * NUM_CH + 20;
    localparam int QUIET_LIMIT  = 2000; // cycles with no transaction at all

    localparam logic SW_OFF    = 1'b0;
    localparam logic SW_ON     = 1'b1;

    // Tracks the servo channels as the block should see them and holds the
    // results each accepted transaction must produce, oldest first.
    class ramp_scoreboard;
        logic [msr_pkg::CFG_DATA_W-1:0] lower_a, lower_b, upper_a, upper_b;
        logic [msr_pkg::PRESENT_W-1:0]  present;
        bit                             moving[NUM_CH];
        logic [msr_pkg::ANGLE_W-1:0]    pos[NUM_CH];
        logic [msr_pkg::ANGLE_W-1:0]    goal[NUM_CH];
        msr_pkg::msr_result_t           due[$];
        int                             mismatches;

        function new();
            lower_a    = '0;
            lower_b    = '0;
            upper_a    = '0;
            upper_b    = '0;
            present    = '0;
            mismatches = 0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                moving[c] = 1'b0;
                pos[c]    = '0;
                goal[c]   = '0;
            end
        endfunction

        function logic [msr_pkg::PULSE_W-1:0] pulse_us(logic [msr_pkg::ANGLE_W-1:0] deg);
            return msr_pkg::PULSE_W'(500 + (int'(deg) * 2000) / 180);
        endfunction

        function void push_result(msr_pkg::msr_event_t kind,
                                  logic [msr_pkg::CHAN_W-1:0] ch,
                                  logic [msr_pkg::ANGLE_W-1:0] ang,
                                  logic [msr_pkg::PULSE_W-1:0] pw,
                                  logic hit);
            msr_pkg::msr_result_t r;
            r.kind        = kind;
            r.channel     = ch;
            r.angle       = ang;
            r.pulse_width = pw;
            r.reached     = hit;
            r.last        = 1'b0;
            due.push_back(r);
        endfunction

        function void set_register(logic [msr_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [msr_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                msr_pkg::CFG_LOWER_FIRST:  lower_a = value;
                msr_pkg::CFG_LOWER_SECOND: lower_b = value;
                msr_pkg::CFG_UPPER_FIRST:  upper_a = value;
                msr_pkg::CFG_UPPER_SECOND: upper_b = value;
                msr_pkg::CFG_PRESENT:      present = value[msr_pkg::PRESENT_W-1:0];
                default:                   ;
            endcase
        endfunction

        // Advance the channel state by one accepted transaction.
        function void apply_item(logic op, logic [msr_pkg::CHAN_W-1:0] ch, logic sw);
            logic [msr_pkg::CFG_DATA_W-1:0] word;
            logic [msr_pkg::ANGLE_W-1:0]    tgt;
            logic [msr_pkg::ANGLE_W-1:0]    step;
            int                             first;
            first = due.size();
            if (op == msr_pkg::OP_TICK)
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    if (moving[c])
                    begin
                        step = pos[c];
                        if (step < goal[c])
                            step = step + 1'b1;
                        else if (step > goal[c])
                            step = step - 1'b1;
                        pos[c] = step;
                        if (step == goal[c])
                            moving[c] = 1'b0;
                        push_result(msr_pkg::EV_DRIVE, msr_pkg::CHAN_W'(c), step,
                                    pulse_us(step), !moving[c]);
                    end
                end
            end
            else if (ch >= NUM_CH)
                push_result(msr_pkg::EV_BAD, ch, '0, '0, 1'b0);
            else if (moving[ch])
                push_result(msr_pkg::EV_BUSY, ch, '0, '0, 1'b0);
            else if (ch >= msr_pkg::LIMIT_CH || !present[ch])
                push_result(msr_pkg::EV_NO_LIMITS, ch, '0, '0, 1'b0);
            else
            begin
                if (ch < msr_pkg::LIMITS_PER_REG)
                    word = sw ? upper_a : lower_a;
                else
                    word = sw ? upper_b : lower_b;
                tgt = word[8 * (ch % msr_pkg::LIMITS_PER_REG) +: 8];
                if (tgt > msr_pkg::ANGLE_MAX)
                    tgt = msr_pkg::ANGLE_MAX;
                goal[ch]   = tgt;
                pos[ch]    = msr_pkg::ANGLE_START;
                moving[ch] = (tgt != msr_pkg::ANGLE_START);
                push_result(msr_pkg::EV_START, ch, tgt, '0, 1'b0);
                push_result(msr_pkg::EV_DRIVE, ch, msr_pkg::ANGLE_START,
                            pulse_us(msr_pkg::ANGLE_START), tgt == msr_pkg::ANGLE_START);
            end
            if (due.size() > first)
                due[$].last = 1'b1;
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_result(msr_pkg::msr_result_t got);
            msr_pkg::msr_result_t want;
            if (due.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d channel %0d, expected none",
                         $time, got.kind, got.channel);
                mismatches++;
                return;
            end
            want = due.pop_front();
            if (want.kind !== got.kind)
                report("event_kind", want.kind, got.kind);
            if (want.channel !== got.channel)
                report("out_channel", want.channel, got.channel);
            if (want.angle !== got.angle)
                report("angle", want.angle, got.angle);
            if (want.pulse_width !== got.pulse_width)
                report("pulse_width", want.pulse_width, got.pulse_width);
            if (want.reached !== got.reached)
                report("reached", want.reached, got.reached);
            if (want.last !== got.last)
                report("last", want.last, got.last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    msr_cfg_if cfg_bus();
    msr_in_if  item_bus();
    msr_out_if result_bus();

    multichannel_servo_ramp #(
        .CHANNELS(NUM_CH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (item_bus),
        .result (result_bus)
    );

    ramp_scoreboard       sb;
    bit                   idling       = 1'b1; // cleared for the stretch with no gaps
    bit                   hold_pending = 1'b0; // asks the receiver for one long hold-off
    int                   quiet_cycles;
    msr_pkg::msr_result_t seen;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: drop ready at random, or hold it off for a long stretch on request.
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                result_bus.ready <= !(idling && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Monitor: every handshake is sampled at the edge that completes it, so all
    // values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                sb.set_register(cfg_bus.index, cfg_bus.data);
            if (item_bus.valid && item_bus.ready)
                sb.apply_item(item_bus.operation, item_bus.channel, item_bus.switch_on);
            if (result_bus.valid && result_bus.ready)
            begin
                seen.kind        = msr_pkg::msr_event_t'(result_bus.event_kind);
                seen.channel     = result_bus.out_channel;
                seen.angle       = result_bus.angle;
                seen.pulse_width = result_bus.pulse_width;
                seen.reached     = result_bus.reached;
                seen.last        = result_bus.last;
                sb.check_result(seen);
            end
        end
    end

    // Watchdog: end the run when nothing at all moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_bus.valid && cfg_bus.ready) || (item_bus.valid && item_bus.ready)
            || (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Offer one command or tick and hold it until the block takes it. Valid stays
    // high into the next call unless that call opens with idle cycles.
    task automatic send_item(input logic op, input logic [msr_pkg::CHAN_W-1:0] ch,
                             input logic sw);
        while (idling && $urandom_range(99) < IDLE_PCT)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.operation <= op;
        item_bus.channel   <= ch;
        item_bus.switch_on <= sw;
        do @(posedge clk); while (!item_bus.ready);
    endtask

    task automatic write_reg(input msr_pkg::msr_cfg_index_t idx,
                             input logic [msr_pkg::CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    task automatic load_limits(input logic [msr_pkg::CFG_DATA_W-1:0] lo_a,
                               input logic [msr_pkg::CFG_DATA_W-1:0] lo_b,
                               input logic [msr_pkg::CFG_DATA_W-1:0] up_a,
                               input logic [msr_pkg::CFG_DATA_W-1:0] up_b,
                               input logic [msr_pkg::PRESENT_W-1:0] have);
        write_reg(msr_pkg::CFG_LOWER_FIRST, lo_a);
        write_reg(msr_pkg::CFG_LOWER_SECOND, lo_b);
        write_reg(msr_pkg::CFG_UPPER_FIRST, up_a);
        write_reg(msr_pkg::CFG_UPPER_SECOND, up_b);
        write_reg(msr_pkg::CFG_PRESENT, msr_pkg::CFG_DATA_W'(have));
        cfg_bus.valid <= 1'b0;
    endtask

    // Stop offering, let every expected result arrive, then give a tick with no
    // result time to leave the block before anything else happens.
    task automatic wait_quiet();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Five limit bytes; near ones stay close to the start angle so ramps finish.
    function automatic logic [msr_pkg::CFG_DATA_W-1:0] random_limits(bit near);
        logic [msr_pkg::CFG_DATA_W-1:0] word;
        for (int k = 0; k < msr_pkg::LIMITS_PER_REG; k++)
            word[8 * k +: 8] = near ? 8'($urandom_range(100, 80)) : 8'($urandom_range(255));
        return word;
    endfunction

    // Mostly ticks and commands on real channels, with some out-of-range noise.
    task automatic send_random(input int count);
        int unsigned pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_item(msr_pkg::OP_TICK, msr_pkg::CHAN_W'($urandom_range(15)),
                          1'($urandom_range(1)));
            else if (pick < 88)
                send_item(msr_pkg::OP_SWITCH, msr_pkg::CHAN_W'($urandom_range(NUM_CH - 1)),
                          1'($urandom_range(1)));
            else
                send_item(msr_pkg::OP_SWITCH, msr_pkg::CHAN_W'($urandom_range(15)),
                          1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n              = 1'b0;
        item_bus.valid     = 1'b0;
        item_bus.operation = msr_pkg::OP_SWITCH;
        item_bus.channel   = '0;
        item_bus.switch_on = SW_OFF;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = msr_pkg::CFG_LOWER_FIRST;
        cfg_bus.data       = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset: tick with nothing busy, no limits, bad channel.
        send_item(msr_pkg::OP_TICK, 4'd0, SW_OFF);
        send_item(msr_pkg::OP_SWITCH, 4'd0, SW_ON);
        send_item(msr_pkg::OP_SWITCH, 4'd15, SW_ON);
        wait_quiet();

        // Short ramps around 90, a 90 target on both sides of channel 2, limits
        // over 180 for clamping, and channel 3 left without limits.
        load_limits({8'd255, 8'd92, 8'd90, 8'd0, 8'd88},
                    {8'd200, 8'd180, 8'd90, 8'd91, 8'd87},
                    {8'd89, 8'd180, 8'd90, 8'd255, 8'd93},
                    {8'd0, 8'd90, 8'd200, 8'd86, 8'd94},
                    10'h3F7);
        send_item(msr_pkg::OP_SWITCH, 4'd0, SW_ON);   // ramp 90 -> 93
        send_item(msr_pkg::OP_SWITCH, 4'd0, SW_OFF);  // busy
        send_item(msr_pkg::OP_SWITCH, 4'd2, SW_ON);   // target 90, arrives at once
        send_item(msr_pkg::OP_SWITCH, 4'd2, SW_OFF);
        send_item(msr_pkg::OP_SWITCH, 4'd3, SW_ON);   // no limits
        send_item(msr_pkg::OP_SWITCH, 4'd4, SW_OFF);  // 255 clamps to 180
        send_item(msr_pkg::OP_SWITCH, 4'd9, SW_OFF);  // 200 clamps to 180
        send_item(msr_pkg::OP_SWITCH, 4'd8, SW_ON);   // target 90
        send_item(msr_pkg::OP_SWITCH, 4'd1, SW_OFF);  // ramp down to 0
        send_item(msr_pkg::OP_SWITCH, 4'd10, SW_OFF); // just past the last channel
        send_item(msr_pkg::OP_SWITCH, 4'd12, SW_ON);
        repeat (4) send_item(msr_pkg::OP_TICK, 4'd15, SW_ON);
        send_item(msr_pkg::OP_SWITCH, 4'd0, SW_OFF);  // back down to 88
        send_item(msr_pkg::OP_SWITCH, 4'd6, SW_ON);   // ramp 90 -> 86
        repeat (3) send_item(msr_pkg::OP_TICK, 4'd5, SW_OFF);
        wait_quiet();

        // Limits near the start angle so most ramps reach their target.
        load_limits(random_limits(1'b1), random_limits(1'b1), random_limits(1'b1),
                    random_limits(1'b1), msr_pkg::PRESENT_W'($urandom_range(1023)));
        send_random(45);
        wait_quiet();

        // No gaps on either side; partway in, hold the receiver off so the
        // block fills and stalls the command channel.
        idling = 1'b0;
        load_limits(random_limits(1'b0), random_limits(1'b0), random_limits(1'b0),
                    random_limits(1'b0), 10'h3FF);
        send_random(5);
        hold_pending = 1'b1;
        send_random(40);
        wait_quiet();
        idling = 1'b1;

        // Register extremes.
        load_limits('0, '1, '1, '0, 10'h3FF);
        send_random(35);
        wait_quiet();

        // Limits withdrawn everywhere while earlier ramps may still be running.
        load_limits(random_limits(1'b1), random_limits(1'b1), random_limits(1'b1),
                    random_limits(1'b1), '0);
        send_random(10);
        wait_quiet();

        if (sb.mismatches == 0 && sb.due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
